FILE: rtl/core/sobel_edge_magnitude_assert.svh
// Assertion macros for the Sobel edge magnitude block.
// Each expects clk and rst_n in scope at the point of use.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SEM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel_edge_magnitude: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SEM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel_edge_magnitude: next-cycle check failed");

`endif

FILE: rtl/core/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; used by every module of the block except sem_fifo.
`timescale 1ns / 1ps

package sem_pkg;

  localparam int PIX_W         = 8;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;
  localparam int CFG_WW        = 11;
  localparam int CFG_HW        = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam int MID_DEPTH = 4;
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Window indexed [row][column]; row 0 is the top, column 0 the oldest.
  typedef logic [2:0][2:0][PIX_W-1:0] sem_win_t;

  typedef struct packed {
    logic interior;
    logic frame_end;
    logic result_valid;
  } sem_tag_t;

  typedef struct packed {
    sem_win_t win;
    sem_tag_t tag;
  } sem_rec_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_magnitude;
    logic             frame_end;
    logic             result_valid;
  } sem_res_t;

endpackage

FILE: rtl/core/sem_fifo.sv
// Small register FIFO used between the parts of the Sobel block.
// Self-contained; no package dependency.
`timescale 1ns / 1ps

module sem_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic [CNT_W-1:0] count,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = store_r[rd_ptr_r];
  assign count = count_r;
  assign empty = (count_r == '0);

endmodule

FILE: rtl/core/sem_front.sv
// Front part of the Sobel block: configuration, raster counters, line memory
// and the 3x3 window. Depends on sem_pkg; feeds the middle FIFO.
`timescale 1ns / 1ps

module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [sem_pkg::PIX_W-1:0]       in_gray_pixel,
  input  logic [sem_pkg::MID_CNT_W-1:0]   mid_count,
  output logic                            rec_push,
  output sem_pkg::sem_rec_t               rec_data
);

  import sem_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int FILL_W = $clog2(MAX_WIDTH + 2);

  logic [CFG_WW-1:0]  cfg_width_r;
  logic [CFG_HW-1:0]  cfg_height_r;
  logic [EW-1:0]      eff_w;
  logic [CFG_HW-1:0]  eff_h;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic               accept;
  logic               res_valid;
  sem_tag_t           tag_nxt;

  logic               a_valid_r;
  logic [COL_W-1:0]   a_addr_r;
  logic [PIX_W-1:0]   a_px_r;
  sem_tag_t           a_tag_r;
  logic [2*PIX_W-1:0] rd_data_r;

  // Each entry holds {upper row, middle row} for one column.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  sem_win_t           win_r, win_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_WW'(WIDTH_RESET);
      cfg_height_r <= CFG_HW'(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  cfg_width_r  <= cfg_wdata[CFG_WW-1:0];
        CFG_IDX_HEIGHT: cfg_height_r <= cfg_wdata[CFG_HW-1:0];
        default:        cfg_width_r  <= cfg_width_r;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r < CFG_WW'(3)) begin
      eff_w = EW'(3);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_width_r);
    end
    if (cfg_height_r < CFG_HW'(3)) begin
      eff_h = CFG_HW'(3);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = CFG_HW'(MAX_HEIGHT);
    end else begin
      eff_h = cfg_height_r;
    end
  end

  // Room is reserved for the beat still waiting on its line memory read.
  assign in_full = (32'(mid_count) + 32'(a_valid_r)) >= 32'(MID_DEPTH);
  assign accept  = in_push && !in_full;

  always_comb begin
    cur_col  = (32'(col_r) >= 32'(eff_w)) ? COL_W'(eff_w - EW'(1)) : col_r;
    cur_row  = (32'(row_r) >= 32'(eff_h)) ? ROW_W'(eff_h - CFG_HW'(1)) : row_r;
    res_valid = 32'(fill_r) >= (32'(eff_w) + 32'd1);
    fill_nxt = res_valid ? fill_r : fill_r + FILL_W'(1);

    tag_nxt.result_valid = res_valid;
    tag_nxt.interior     = res_valid && (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    tag_nxt.frame_end    = res_valid && (cur_row == ROW_W'(1)) && (cur_col == '0);

    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if ((32'(col_r) + 32'd1) >= 32'(eff_w)) begin
      col_nxt = '0;
      row_nxt = ((32'(row_r) + 32'd1) >= 32'(eff_h)) ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      fill_r    <= '0;
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_addr_r <= cur_col;
      a_px_r   <= in_gray_pixel;
      a_tag_r  <= tag_nxt;
    end
  end

  // A column is read when its pixel arrives and rewritten in the next cycle;
  // consecutive beats never share a column, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= line_mem[cur_col];
    end
    if (a_valid_r) begin
      line_mem[a_addr_r] <= {rd_data_r[PIX_W-1:0], a_px_r};
    end
  end

  always_comb begin
    win_nxt = win_r;
    if (a_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[k][0] = win_r[k][1];
        win_nxt[k][1] = win_r[k][2];
      end
      win_nxt[0][2] = rd_data_r[2*PIX_W-1:PIX_W];
      win_nxt[1][2] = rd_data_r[PIX_W-1:0];
      win_nxt[2][2] = a_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign rec_push     = a_valid_r;
  assign rec_data.win = win_nxt;
  assign rec_data.tag = a_tag_r;

endmodule

FILE: rtl/core/sem_back.sv
// Back part of the Sobel block: gradient sums, squares and a pipelined
// integer square root. Depends on sem_pkg; drains the middle FIFO.
`timescale 1ns / 1ps

module sem_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mid_empty,
  input  sem_pkg::sem_rec_t             mid_data,
  output logic                          mid_pop,
  input  logic [sem_pkg::OUT_CNT_W-1:0] out_count,
  output logic                          res_push,
  output sem_pkg::sem_res_t             res_data
);

  import sem_pkg::*;

  localparam logic [3:0] SQRT_HI_SHIFT = 4'd14;
  localparam logic [3:0] SQRT_LO_SHIFT = 4'd6;

  // Four steps of the bit-pair square root; returns {remainder, root}.
  function automatic logic [33:0] sqrt_steps(input logic [16:0] v_in,
                                             input logic [16:0] res_in,
                                             input logic [3:0]  top_shift);
    logic [16:0] v;
    logic [16:0] res;
    logic [16:0] b;
    v   = v_in;
    res = res_in;
    for (int k = 0; k < 4; k++) begin
      b = 17'(1) << (top_shift - 4'(2 * k));
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return {v, res};
  endfunction

  logic [PIX_W+1:0] posx, negx, posy, negy;
  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  sem_tag_t         s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [PIX_W+1:0] s1_ax_r, s1_ay_r;
  logic [19:0]      s2_sqx_r, s2_sqy_r;
  logic [20:0]      sum;
  logic             s3_sat_r;
  logic [15:0]      s3_v_val_r;
  logic [33:0]      hi_step, lo_step;
  logic [16:0]      s4_rem_r, s4_res_r;
  logic             s4_sat_r;
  logic [PIX_W-1:0] mag;
  sem_win_t         w;

  // Credit check: every beat in flight already owns a slot in the output FIFO.
  assign mid_pop = !mid_empty &&
                   ((32'(out_count) + 32'(s1_v_r) + 32'(s2_v_r) + 32'(s3_v_r)
                     + 32'(s4_v_r)) < 32'(OUT_DEPTH));

  assign w = mid_data.win;

  always_comb begin
    posx = 10'(w[0][2]) + {1'b0, w[1][2], 1'b0} + 10'(w[2][2]);
    negx = 10'(w[0][0]) + {1'b0, w[1][0], 1'b0} + 10'(w[2][0]);
    posy = 10'(w[0][0]) + {1'b0, w[0][1], 1'b0} + 10'(w[0][2]);
    negy = 10'(w[2][0]) + {1'b0, w[2][1], 1'b0} + 10'(w[2][2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= mid_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  assign sum     = 21'(s2_sqx_r) + 21'(s2_sqy_r);
  assign hi_step = sqrt_steps({1'b0, s3_v_val_r}, 17'd0, SQRT_HI_SHIFT);
  assign lo_step = sqrt_steps(s4_rem_r, s4_res_r, SQRT_LO_SHIFT);

  always_ff @(posedge clk) begin
    s1_tag_r   <= mid_data.tag;
    s1_ax_r    <= (posx >= negx) ? posx - negx : negx - posx;
    s1_ay_r    <= (posy >= negy) ? posy - negy : negy - posy;
    s2_tag_r   <= s1_tag_r;
    s2_sqx_r   <= s1_ax_r * s1_ax_r;
    s2_sqy_r   <= s1_ay_r * s1_ay_r;
    s3_tag_r   <= s2_tag_r;
    s3_sat_r   <= (sum[20:16] != '0);
    s3_v_val_r <= sum[15:0];
    s4_tag_r   <= s3_tag_r;
    s4_sat_r   <= s3_sat_r;
    s4_rem_r   <= hi_step[33:17];
    s4_res_r   <= hi_step[16:0];
  end

  always_comb begin
    if (!s4_tag_r.interior) begin
      mag = '0;
    end else if (s4_sat_r) begin
      mag = '1;
    end else begin
      mag = lo_step[PIX_W-1:0];
    end
  end

  assign res_push                = s4_v_r;
  assign res_data.edge_magnitude = mag;
  assign res_data.frame_end      = s4_tag_r.frame_end;
  assign res_data.result_valid   = s4_tag_r.result_valid;

endmodule

FILE: rtl/core/sobel_edge_magnitude.sv
// Streaming 3x3 Sobel gradient magnitude over a raster of 8-bit gray pixels.
// Input channel: a pixel beat is taken when in_push is high and in_full low.
// Result channel: the oldest result sits on out_* while out_empty is low and
// leaves when out_pop is high. Every pixel gives exactly one result; that
// result belongs to the pixel taken image_width+1 beats earlier, so the
// first image_width+1 results after reset carry out_result_valid = 0.
// Border pixels give 0, others floor(sqrt(gx^2+gy^2)) saturated to 255.
// Throughput: one pixel per cycle while in_full is low, set by the single
// line memory read and the one-column window shift done for each pixel.
// Registers (cfg_index 0: width, 1: height) are to be written while idle;
// the user is bound to this, and the block itself does not enforce it.
// Reset (synchronous, rst_n low) restores width 640 and height 480, clears
// the counters, window and queues; line memory holds old data.
// When the receiver stalls, the output queue fills, the square-root pipe
// stops drawing from the middle queue and in_full rises as that queue fills.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_assert.svh"

module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [sem_pkg::PIX_W-1:0]      in_gray_pixel,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [sem_pkg::PIX_W-1:0]      out_edge_magnitude,
  output logic                           out_frame_end,
  output logic                           out_result_valid
);

  import sem_pkg::*;

  localparam int REC_W = $bits(sem_rec_t);
  localparam int RES_W = $bits(sem_res_t);

  logic                 mid_wr;
  sem_rec_t             mid_wdata;
  logic                 mid_rd;
  logic [REC_W-1:0]     mid_rdata_vec;
  sem_rec_t             mid_head;
  logic [MID_CNT_W-1:0] mid_count;
  logic                 mid_empty;

  logic                 out_wr;
  sem_res_t             out_wdata;
  logic                 out_rd;
  logic [RES_W-1:0]     out_rdata_vec;
  sem_res_t             out_head;
  logic [OUT_CNT_W-1:0] out_count;

  sem_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_gray_pixel(in_gray_pixel),
    .mid_count    (mid_count),
    .rec_push     (mid_wr),
    .rec_data     (mid_wdata)
  );

  sem_fifo #(
    .WIDTH(REC_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_wr),
    .wdata(mid_wdata),
    .pop  (mid_rd),
    .rdata(mid_rdata_vec),
    .count(mid_count),
    .empty(mid_empty)
  );

  assign mid_head = mid_rdata_vec;

  sem_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mid_empty(mid_empty),
    .mid_data (mid_head),
    .mid_pop  (mid_rd),
    .out_count(out_count),
    .res_push (out_wr),
    .res_data (out_wdata)
  );

  assign out_rd = out_pop && !out_empty;

  sem_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (out_wr),
    .wdata(out_wdata),
    .pop  (out_rd),
    .rdata(out_rdata_vec),
    .count(out_count),
    .empty(out_empty)
  );

  assign out_head           = out_rdata_vec;
  assign out_edge_magnitude = out_head.edge_magnitude;
  assign out_frame_end      = out_head.frame_end;
  assign out_result_valid   = out_head.result_valid;

  // The credit checks must keep both queues from ever being written while full.
  `SEM_ASSERT_NOW(a_mid_no_overflow, mid_wr, mid_count != MID_CNT_W'(MID_DEPTH))
  `SEM_ASSERT_NOW(a_out_no_overflow, out_wr, out_count != OUT_CNT_W'(OUT_DEPTH))
  // A pixel beat is written to the middle queue in the cycle after it is taken.
  `SEM_ASSERT_NEXT(a_front_latency, in_push && !in_full, mid_wr)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for sobel_edge_magnitude: streams gray pixel beats,
// predicts every result beat in a scoreboard class and compares field by field.
// Depends on sem_pkg and the sobel_edge_magnitude RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sem_pkg::*;

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_RAMP, TEXTURE_FLAT} texture_t;

  // Tracks the frame position, line stores and window of the block and keeps
  // the queue of result beats that the accepted pixels must produce.
  class edge_scoreboard;
    logic [CFG_WW-1:0] width_reg;
    logic [CFG_HW-1:0] height_reg;
    logic [PIX_W-1:0]  upper_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  middle_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  win [3][3];
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    int unsigned       fill_cnt;
    int unsigned       mismatches;
    sem_res_t          expected_q [$];

    function new();
      width_reg  = CFG_WW'(WIDTH_RESET);
      height_reg = CFG_HW'(HEIGHT_RESET);
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      fill_cnt   = 0;
      mismatches = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IDX_WIDTH) width_reg = data[CFG_WW-1:0];
      else if (idx == CFG_IDX_HEIGHT) height_reg = data[CFG_HW-1:0];
    endfunction

    function logic [PIX_W-1:0] gradient_magnitude();
      int p [3][3];
      int gx;
      int gy;
      int sq;
      int root;
      foreach (win[i, j]) p[i][j] = int'(win[i][j]);
      gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
      gy = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
      sq = gx * gx + gy * gy;
      if (sq >= 65536) return 8'hFF;
      root = 0;
      while ((root + 1) * (root + 1) <= sq) root++;
      return PIX_W'(root);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      sem_res_t    res;
      w = eff_width();
      h = eff_height();
      c = col_cnt;
      r = row_cnt;
      // Counters left past the end by a smaller setting act as the last one.
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      res = '0;
      if (fill_cnt >= w + 1) begin
        res.result_valid = 1'b1;
        if (r >= 2 && c >= 2) res.edge_magnitude = gradient_magnitude();
        if (r == 1 && c == 0) res.frame_end = 1'b1;
      end else begin
        fill_cnt++;
      end
      if (col_cnt + 1 >= w) begin
        col_cnt = 0;
        if (row_cnt + 1 >= h) row_cnt = 0;
        else row_cnt++;
      end else begin
        col_cnt++;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [PIX_W-1:0] mag, logic fend, logic valid);
      sem_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (mag %0d frame_end %b valid %b)",
                 $time, mag, fend, valid);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (mag !== want.edge_magnitude) begin
        $display("%0t: edge_magnitude expected %0d actual %0d",
                 $time, want.edge_magnitude, mag);
        mismatches++;
      end
      if (fend !== want.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, fend);
        mismatches++;
      end
      if (valid !== want.result_valid) begin
        $display("%0t: result_valid expected %b actual %b",
                 $time, want.result_valid, valid);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_push;
  logic                  in_full;
  logic [PIX_W-1:0]      in_gray_pixel;
  logic                  out_empty;
  logic                  out_pop;
  logic [PIX_W-1:0]      out_edge_magnitude;
  logic                  out_frame_end;
  logic                  out_result_valid;

  edge_scoreboard sb;
  int unsigned    pixels_sent;
  bit             feed_calm;

  // Three 3x3 frames: saturated vertical edge, flat white, small gradient.
  logic [PIX_W-1:0] seed_frames [0:26] = '{
    8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd7,   8'd3,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd9,   8'd2
  };

  sobel_edge_magnitude DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_gray_pixel      (in_gray_pixel),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_edge_magnitude (out_edge_magnitude),
    .out_frame_end      (out_frame_end),
    .out_result_valid   (out_result_valid)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result(out_edge_magnitude, out_frame_end, out_result_valid);
  end

  // Receiver: pops with random stalls, and now and then a calm stretch.
  initial begin : pop_driver
    int unsigned hold;
    bit          calm;
    hold    = 0;
    calm    = 1'b0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (hold != 0) begin
        out_pop <= 1'b0;
        hold--;
      end else begin
        out_pop <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("sobel_edge_magnitude regression: fail");
    $finish;
  end

  function automatic int unsigned next_gap();
    int unsigned roll;
    if ($urandom_range(0, 99) < 2) feed_calm = !feed_calm;
    if (feed_calm) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(texture_t tex);
    case (tex)
      TEXTURE_NOISE:  return PIX_W'($urandom_range(0, 255));
      TEXTURE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      TEXTURE_RAMP:   return PIX_W'(sb.col_cnt * 23 + sb.row_cnt * 41 + $urandom_range(0, 3));
      default:        return PIX_W'(120 + $urandom_range(0, 4));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_pixel(logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push       <= 1'b1;
    in_gray_pixel <= px;
    do @(posedge clk); while (in_full);
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic stream(int unsigned count, texture_t tex);
    repeat (count) send_pixel(make_pixel(tex));
  endtask

  task automatic finish_frame(texture_t tex);
    while (sb.col_cnt != 0 || sb.row_cnt != 0) send_pixel(make_pixel(tex));
  endtask

  // Registers are only written once every result beat has been taken.
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A few whole frames at a small random size. Width only grows at a frame
  // start, so no interior result ever sees a line store entry never written.
  task automatic small_phase();
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    int unsigned           frames;
    int unsigned           w;
    int unsigned           h;
    texture_t              tex;
    wdata = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                        : CFG_DATA_W'($urandom_range(3, 12));
    wdata[CFG_DATA_W-1:CFG_WW] = 2'($urandom_range(0, 3));
    hdata = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                        : CFG_DATA_W'($urandom_range(3, 7));
    frames = $urandom_range(1, 3);
    settle();
    write_reg(CFG_IDX_WIDTH, wdata);
    write_reg(CFG_IDX_HEIGHT, hdata);
    repeat (frames) begin
      tex = texture_t'($urandom_range(0, 3));
      stream(sb.eff_width() * sb.eff_height(), tex);
    end
    // Sometimes narrow the frame or change its height once two rows are in.
    if ($urandom_range(0, 3) == 0) begin
      w = sb.eff_width();
      h = sb.eff_height();
      stream($urandom_range(2 * w, h * w - 2), TEXTURE_NOISE);
      settle();
      write_reg(CFG_IDX_WIDTH, {2'($urandom_range(0, 3)), CFG_WW'($urandom_range(0, w))});
      write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'($urandom_range(0, 9)));
      finish_frame(TEXTURE_NOISE);
    end
  endtask

  initial begin
    sb            = new();
    pixels_sent   = 0;
    feed_calm     = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IDX_WIDTH;
    cfg_wdata     = '0;
    in_push       = 1'b0;
    in_gray_pixel = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out-of-range settings that clamp to a 3x3 frame; the upper data bits
    // of a width write are ignored.
    write_reg(CFG_IDX_WIDTH, 13'h1801);
    write_reg(CFG_IDX_HEIGHT, 13'd2);
    foreach (seed_frames[i]) send_pixel(seed_frames[i]);

    // Shrink both sizes mid-frame with the counters past their new last value.
    settle();
    write_reg(CFG_IDX_WIDTH, 13'd8);
    write_reg(CFG_IDX_HEIGHT, 13'd6);
    stream(37, TEXTURE_NOISE);
    settle();
    write_reg(CFG_IDX_WIDTH, 13'd4);
    write_reg(CFG_IDX_HEIGHT, 13'd3);
    finish_frame(TEXTURE_NOISE);

    while (pixels_sent < 200) small_phase();

    // Tallest frame: the height register is changed on the way down.
    settle();
    write_reg(CFG_IDX_WIDTH, 13'h0803);
    write_reg(CFG_IDX_HEIGHT, 13'h1FFF);
    stream(60, TEXTURE_RAMP);
    settle();
    write_reg(CFG_IDX_HEIGHT, 13'd4096);
    stream(15, TEXTURE_NOISE);
    settle();
    write_reg(CFG_IDX_HEIGHT, 13'd5);
    finish_frame(TEXTURE_NOISE);

    // Widest frame from an oversized width write, narrowed early in its
    // second row to keep the run short.
    settle();
    write_reg(CFG_IDX_WIDTH, 13'd2047);
    write_reg(CFG_IDX_HEIGHT, 13'd3);
    stream(600, TEXTURE_RAMP);
    stream(430, TEXTURE_NOISE);
    settle();
    write_reg(CFG_IDX_WIDTH, 13'd16);
    finish_frame(TEXTURE_BINARY);

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sobel_edge_magnitude regression: pass");
    end else begin
      $display("sobel_edge_magnitude regression: fail");
    end
    $finish;
  end

endmodule
